// ----- sv/windowed_rms_current_ema_top_macros.svh -----
// Assertion macros for the windowed RMS current meter.
`ifndef WINDOWED_RMS_CURRENT_EMA_TOP_MACROS_SVH
`define WINDOWED_RMS_CURRENT_EMA_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define WRCE_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define WRCE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define WRCE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define WRCE_ASSERT(label, expr, msg)
`define WRCE_ASSERT_IMP(label, ante, cons, msg)
`define WRCE_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ----- sv/wrce_pkg.sv -----
`default_nettype none
package wrce_pkg;

	localparam int SUM_W   = 44;
	localparam int ROOT_W  = 22;
	localparam int ITER_W  = 6;
	localparam int MUL_A_W = 30;
	localparam int MUL_B_W = 20;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int CUR_W   = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NOISE_GATE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_VALID    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CURRENT  = 3'd5;

	localparam logic [15:0] ZERO_OFFSET_RST  = 16'd32768;
	localparam logic [14:0] NOISE_GATE_RST   = 15'd160;
	localparam logic [19:0] COUNT_GAIN_RST   = 20'd73080;
	localparam logic [15:0] SCALE_FACTOR_RST = 16'd16384;
	localparam logic [19:0] MAX_CURRENT_RST  = 20'd655360;

	localparam logic [15:0] ALPHA_Q16     = 16'd19661;
	localparam logic [15:0] ONE_MINUS_Q16 = 16'd45875;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MAG,
		ST_SQ,
		ST_ACC,
		ST_DIVS,
		ST_DIVW,
		ST_SQS,
		ST_SQW,
		ST_GAIN,
		ST_GRND,
		ST_SCL,
		ST_SRND,
		ST_REJ,
		ST_EMA1,
		ST_EMA2,
		ST_EMA3,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic sqrt;
	} ds_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ds_stat_t;

endpackage
`default_nettype wire

// ----- sv/windowed_rms_current_ema_top.sv -----
// Sample word: from accept to ready again it steps through latch, magnitude, square, accumulate.
// Window-end word: the result word is registered after the 44-step division and 22-step
// square root of the shared shift-subtract unit (skipped for an empty window) and the
// shared 30x20 multiplier (gain, calibration, two EMA products); a stalled result waits in emit.
// Input stalls whenever the sequencer is not idle, so a new word waits for the last to finish.
// Reset: asynchronous; sum, count and filter clear, first window set, registers to defaults.
`default_nettype none
`include "windowed_rms_current_ema_top_macros.svh"
module windowed_rms_current_ema_top #(
	parameter int MAX_WINDOW_SAMPLES = 8192
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [wrce_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [wrce_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [11:0]                     sample,
	input  wire logic                            read_ok,
	input  wire logic                            window_end,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [19:0]                     filtered_current,
	output logic      [19:0]                     window_current,
	output logic                                 reading_rejected,
	output logic      [13:0]                     window_samples
);
	import wrce_pkg::*;

	localparam int CNT_W = $clog2(MAX_WINDOW_SAMPLES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOW_SAMPLES);

	state_t state_q, state_d;

	logic [15:0] zoff_q;
	logic [14:0] gate_q;
	logic [19:0] gain_q;
	logic [15:0] scale_q;
	logic        cal_q;
	logic [19:0] max_q;

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [19:0]      filt_q;
	logic             first_q;

	logic [11:0]       sample_q;
	logic              ok_q;
	logic              wend_q;
	logic              take_q;
	logic [15:0]       mag_q;
	logic [ROOT_W-1:0] rms_q;
	logic [CUR_W-1:0]  cur_q;
	logic              rej_q;
	logic [19:0]       cur20_q;
	logic [19:0]       nf_q;
	logic [35:0]       acc_q;

	logic        out_valid_q;
	logic [19:0] out_filt_q;
	logic [19:0] out_cur_q;
	logic        out_rej_q;
	logic [13:0] out_cnt_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod_q;
	ds_req_t            ds_req;
	ds_stat_t           ds_stat;
	logic [SUM_W-1:0]   ds_quot;
	logic [ROOT_W-1:0]  ds_root;

	logic               in_acc;
	logic               emit_go;
	logic signed [17:0] diff;
	logic signed [17:0] diff_c;
	logic        [17:0] diff_abs;
	logic        [15:0] mag;
	logic [SUM_W:0]     sum_add;
	logic [42:0]        grnd;
	logic [46:0]        srnd;
	logic [36:0]        ema_sum;
	logic               rej;
	logic [19:0]        cur20;
	logic [CNT_W+13:0]  cnt_ext;

	wrce_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	wrce_divsqrt #(
		.CNT_W (CNT_W)
	) u_divsqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ds_req),
		.operand ((state_q == ST_SQS) ? ds_quot : sum_q),
		.divisor (cnt_q),
		.stat    (ds_stat),
		.quot    (ds_quot),
		.root    (ds_root)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign emit_go   = !out_valid_q || !out_stall;

	always_comb begin
		diff   = $signed({2'b00, sample_q, 4'b0000}) - $signed({2'b00, zoff_q});
		diff_c = diff;
		if (diff > 18'sd32752) begin
			diff_c = 18'sd32752;
		end
		if (diff < -18'sd32768) begin
			diff_c = -18'sd32768;
		end
		diff_abs = diff_c[17] ? 18'(-diff_c) : 18'(diff_c);
		mag      = (diff_abs[15:0] < {1'b0, gate_q}) ? 16'd0 : diff_abs[15:0];
		sum_add  = {1'b0, sum_q} + (SUM_W+1)'(prod_q[30:0]);
		grnd     = {1'b0, prod_q[41:0]} + 43'd2048;
		srnd     = {1'b0, prod_q[45:0]} + 47'd8192;
		ema_sum  = {1'b0, acc_q} + {1'b0, prod_q[35:0]} + 37'd32768;
		rej      = cur_q > {12'd0, max_q};
		cur20    = rej ? 20'd0 : cur_q[19:0];
		cnt_ext  = {14'd0, cnt_q};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_MAG;
				end
			end
			ST_MAG:  state_d = ST_SQ;
			ST_SQ:   state_d = ST_ACC;
			ST_ACC:  state_d = wend_q ? ST_DIVS : ST_IDLE;
			ST_DIVS: state_d = (cnt_q == '0) ? ST_GAIN : ST_DIVW;
			ST_DIVW: begin
				if (ds_stat.done) begin
					state_d = ST_SQS;
				end
			end
			ST_SQS:  state_d = ST_SQW;
			ST_SQW: begin
				if (ds_stat.done) begin
					state_d = ST_GAIN;
				end
			end
			ST_GAIN: state_d = ST_GRND;
			ST_GRND: state_d = cal_q ? ST_SCL : ST_REJ;
			ST_SCL:  state_d = ST_SRND;
			ST_SRND: state_d = ST_REJ;
			ST_REJ:  state_d = first_q ? ST_EMIT : ST_EMA1;
			ST_EMA1: state_d = ST_EMA2;
			ST_EMA2: state_d = ST_EMA3;
			ST_EMA3: state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mul_a        = '0;
		mul_b        = '0;
		ds_req.start = 1'b0;
		ds_req.sqrt  = 1'b0;
		unique case (state_q)
			ST_SQ: begin
				mul_a = MUL_A_W'(mag_q);
				mul_b = MUL_B_W'(mag_q);
			end
			ST_DIVS: begin
				ds_req.start = (cnt_q != '0);
			end
			ST_SQS: begin
				ds_req.start = 1'b1;
				ds_req.sqrt  = 1'b1;
			end
			ST_GAIN: begin
				mul_a = MUL_A_W'(rms_q);
				mul_b = gain_q;
			end
			ST_SCL: begin
				mul_a = cur_q[MUL_A_W-1:0];
				mul_b = MUL_B_W'(scale_q);
			end
			ST_EMA1: begin
				mul_a = MUL_A_W'(cur20_q);
				mul_b = MUL_B_W'(ALPHA_Q16);
			end
			ST_EMA2: begin
				mul_a = MUL_A_W'(filt_q);
				mul_b = MUL_B_W'(ONE_MINUS_Q16);
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoff_q  <= ZERO_OFFSET_RST;
			gate_q  <= NOISE_GATE_RST;
			gain_q  <= COUNT_GAIN_RST;
			scale_q <= SCALE_FACTOR_RST;
			cal_q   <= 1'b0;
			max_q   <= MAX_CURRENT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ZERO_OFFSET:  zoff_q  <= cfg_data[15:0];
				CFG_NOISE_GATE:   gate_q  <= cfg_data[14:0];
				CFG_COUNT_GAIN:   gain_q  <= cfg_data;
				CFG_SCALE_FACTOR: scale_q <= cfg_data[15:0];
				CFG_CAL_VALID:    cal_q   <= cfg_data[0];
				CFG_MAX_CURRENT:  max_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			cnt_q       <= '0;
			filt_q      <= '0;
			first_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && !out_stall && !(state_q == ST_EMIT && emit_go)) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_ACC && take_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (ok_q) begin
					sum_q <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
				end
			end
			if (state_q == ST_EMIT && emit_go) begin
				out_valid_q <= 1'b1;
				filt_q      <= nf_q;
				first_q     <= 1'b0;
				sum_q       <= '0;
				cnt_q       <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					sample_q <= sample;
					ok_q     <= read_ok;
					wend_q   <= window_end;
					take_q   <= cnt_q < CNT_MAX;
				end
			end
			ST_MAG:  mag_q <= mag;
			ST_DIVS: rms_q <= '0;
			ST_SQW: begin
				if (ds_stat.done) begin
					rms_q <= ds_root;
				end
			end
			ST_GRND: cur_q <= CUR_W'(grnd[42:12]);
			ST_SRND: cur_q <= srnd[45:14];
			ST_REJ: begin
				rej_q   <= rej;
				cur20_q <= cur20;
				nf_q    <= cur20;
			end
			ST_EMA2: acc_q <= prod_q[35:0];
			ST_EMA3: nf_q  <= ema_sum[35:16];
			ST_EMIT: begin
				if (emit_go) begin
					out_filt_q <= nf_q;
					out_cur_q  <= cur20_q;
					out_rej_q  <= rej_q;
					out_cnt_q  <= cnt_ext[13:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid        = out_valid_q;
	assign filtered_current = out_filt_q;
	assign window_current   = out_cur_q;
	assign reading_rejected = out_rej_q;
	assign window_samples   = out_cnt_q;

	`WRCE_ASSERT(a_count_bound, cnt_q <= CNT_MAX, "sample count above window maximum")
	`WRCE_ASSERT_IMP(a_rejected_zero, out_valid_q && out_rej_q, out_cur_q == 20'd0,
		"rejected word carries nonzero current")
	`WRCE_ASSERT_NXT(a_accept_advance, in_acc, state_q == ST_MAG,
		"accepted word did not advance sequencer")

endmodule
`default_nettype wire

// ----- sv/wrce_mul.sv -----
`default_nettype none
module wrce_mul (
	input  wire logic                         clk,
	input  wire logic [wrce_pkg::MUL_A_W-1:0] a,
	input  wire logic [wrce_pkg::MUL_B_W-1:0] b,
	output logic      [wrce_pkg::MUL_P_W-1:0] p_q
);
	import wrce_pkg::*;

	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule
`default_nettype wire

// ----- sv/wrce_divsqrt.sv -----
`default_nettype none
`include "windowed_rms_current_ema_top_macros.svh"
module wrce_divsqrt #(
	parameter int CNT_W = 14
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire wrce_pkg::ds_req_t           req,
	input  wire logic [wrce_pkg::SUM_W-1:0]  operand,
	input  wire logic [CNT_W-1:0]            divisor,
	output wrce_pkg::ds_stat_t               stat,
	output logic      [wrce_pkg::SUM_W-1:0]  quot,
	output logic      [wrce_pkg::ROOT_W-1:0] root
);
	import wrce_pkg::*;

	localparam int RW = (CNT_W + 1 > 2 * ROOT_W - ROOT_W + 2) ? CNT_W + 1 : ROOT_W + 2;

	logic              busy_q;
	logic              done_q;
	logic              mode_q;
	logic [ITER_W-1:0] iter_q;
	logic [SUM_W-1:0]  val_q;
	logic [RW-1:0]     rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  den_q;

	logic [RW-1:0] op_a;
	logic [RW-1:0] op_b;
	logic [RW-1:0] diff;
	logic          ge;

	always_comb begin
		if (mode_q) begin
			op_a = {rem_q[RW-3:0], val_q[SUM_W-1 -: 2]};
			op_b = {{(RW-ROOT_W-2){1'b0}}, root_q, 2'b01};
		end else begin
			op_a = {rem_q[RW-2:0], val_q[SUM_W-1]};
			op_b = {{(RW-CNT_W){1'b0}}, den_q};
		end
		ge   = op_a >= op_b;
		diff = op_a - op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				iter_q <= req.sqrt ? ITER_W'(ROOT_W) : ITER_W'(SUM_W);
			end else if (busy_q) begin
				iter_q <= iter_q - 1'b1;
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mode_q <= req.sqrt;
			val_q  <= operand;
			rem_q  <= '0;
			root_q <= '0;
			den_q  <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff : op_a;
			if (mode_q) begin
				val_q  <= {val_q[SUM_W-3:0], 2'b00};
				root_q <= {root_q[ROOT_W-2:0], ge};
			end else begin
				val_q <= {val_q[SUM_W-2:0], ge};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = val_q;
	assign root      = root_q;

	`WRCE_ASSERT_IMP(a_start_when_free, req.start, !busy_q, "start while unit busy")
	`WRCE_ASSERT_IMP(a_iter_range, busy_q, (iter_q != '0) && (iter_q <= ITER_W'(SUM_W)),
		"iteration count out of range")
	`WRCE_ASSERT_NXT(a_finish, busy_q && (iter_q == ITER_W'(1)) && !req.start,
		done_q && !busy_q, "unit did not finish on last step")

endmodule
`default_nettype wire
